@@ src/rrsa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the rotate/translate source address generator.
// No dependencies; every other file refers to it by scoped names.
package rrsa_pkg;

  localparam int unsigned MAX_DIM            = 4096;
  localparam int unsigned TRIG_FRACTION_BITS = 14;
  localparam int unsigned POS_FRAC_BITS      = 8;
  localparam int unsigned SCALE_BITS         = POS_FRAC_BITS + TRIG_FRACTION_BITS;

  localparam int unsigned DIM_W    = 13;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned INDEX_W  = 24;
  localparam int unsigned TRIG_W   = 16;
  localparam int unsigned SHIFT_W  = 20;

  // Q.8 coordinates, products and the rotated sum.
  localparam int unsigned Q8_W   = 24;
  localparam int unsigned PROD_W = Q8_W + TRIG_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned INT_W  = SUM_W - SCALE_BITS;

  localparam int unsigned NUM_STAGES = 5;

  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [DIM_W-1:0]   MAX_DIM_V      = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0]   RST_WIDTH      = DIM_W'(256);
  localparam logic [DIM_W-1:0]   RST_HEIGHT     = DIM_W'(256);
  localparam logic [TRIG_W-1:0]  RST_COS        = TRIG_W'(16384);
  localparam logic [TRIG_W-1:0]  RST_SIN        = '0;
  localparam logic [SHIFT_W-1:0] RST_SHIFT      = '0;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COS_ANGLE    = 3'd2,
    REG_SIN_ANGLE    = 3'd3,
    REG_SHIFT_X      = 3'd4,
    REG_SHIFT_Y      = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [INDEX_W-1:0] src_index;
    logic               outside;
  } out_t;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [TRIG_W-1:0]  cos_angle;
    logic [TRIG_W-1:0]  sin_angle;
    logic [SHIFT_W-1:0] shift_x;
    logic [SHIFT_W-1:0] shift_y;
  } cfg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    return (d > MAX_DIM_V) ? MAX_DIM_V : d;
  endfunction

endpackage

@@ src/rigid_rotate_source_address.sv @@
`timescale 1ns / 1ps
// Five register stages; a result word moves through them in order and is valid at the
// output once it is in the fifth stage. Throughput: one word per cycle unless the output
// stalls; the four 24x16 multipliers in stage two are each used once. A stalled output
// holds its word while empty stages upstream still take new words.
// Reset (asynchronous, active low) empties the pipeline and loads the register defaults:
// 256 x 256 image, cosine 1.0, sine 0, no shift.
module rigid_rotate_source_address (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rrsa_pkg::ADDR_W-1:0] paddr,
  input  logic [rrsa_pkg::DATA_W-1:0] pwdata,
  output logic [rrsa_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rrsa_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rrsa_pkg::out_t              out_data_o
);

  rrsa_pkg::cfg_t cfg;

  rrsa_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rrsa_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ src/rrsa_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file behind a simple APB-style port.
// Depends on rrsa_pkg for the register map and the cfg_t bundle.
module rrsa_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rrsa_pkg::ADDR_W-1:0] paddr,
  input  logic [rrsa_pkg::DATA_W-1:0] pwdata,
  output logic [rrsa_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rrsa_pkg::cfg_t              cfg_o
);

  rrsa_pkg::cfg_t   cfg_q;
  rrsa_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = rrsa_pkg::reg_idx_e'(paddr[rrsa_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= rrsa_pkg::RST_WIDTH;
      cfg_q.image_height <= rrsa_pkg::RST_HEIGHT;
      cfg_q.cos_angle    <= rrsa_pkg::RST_COS;
      cfg_q.sin_angle    <= rrsa_pkg::RST_SIN;
      cfg_q.shift_x      <= rrsa_pkg::RST_SHIFT;
      cfg_q.shift_y      <= rrsa_pkg::RST_SHIFT;
    end else if (wr_en) begin
      unique case (idx)
        rrsa_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[rrsa_pkg::DIM_W-1:0];
        rrsa_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[rrsa_pkg::DIM_W-1:0];
        rrsa_pkg::REG_COS_ANGLE:    cfg_q.cos_angle    <= pwdata[rrsa_pkg::TRIG_W-1:0];
        rrsa_pkg::REG_SIN_ANGLE:    cfg_q.sin_angle    <= pwdata[rrsa_pkg::TRIG_W-1:0];
        rrsa_pkg::REG_SHIFT_X:      cfg_q.shift_x      <= pwdata[rrsa_pkg::SHIFT_W-1:0];
        rrsa_pkg::REG_SHIFT_Y:      cfg_q.shift_y      <= pwdata[rrsa_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rrsa_pkg::REG_IMAGE_WIDTH:  prdata = rrsa_pkg::DATA_W'(cfg_q.image_width);
      rrsa_pkg::REG_IMAGE_HEIGHT: prdata = rrsa_pkg::DATA_W'(cfg_q.image_height);
      rrsa_pkg::REG_COS_ANGLE:    prdata = rrsa_pkg::DATA_W'(cfg_q.cos_angle);
      rrsa_pkg::REG_SIN_ANGLE:    prdata = rrsa_pkg::DATA_W'(cfg_q.sin_angle);
      rrsa_pkg::REG_SHIFT_X:      prdata = rrsa_pkg::DATA_W'(cfg_q.shift_x);
      rrsa_pkg::REG_SHIFT_Y:      prdata = rrsa_pkg::DATA_W'(cfg_q.shift_y);
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/rrsa_pipe.sv @@
`timescale 1ns / 1ps
// Five-stage datapath: center offsets, rotation products, sums, truncation with
// bounds check, and linear index. Depends on rrsa_pkg.
module rrsa_pipe (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rrsa_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rrsa_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rrsa_pkg::out_t out_data_o
);

  localparam int unsigned NS = rrsa_pkg::NUM_STAGES;
  localparam int unsigned PAD_W = rrsa_pkg::Q8_W - rrsa_pkg::COORD_W - rrsa_pkg::POS_FRAC_BITS;

  // Each stage loads when it is empty or when the stage after it loads.
  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o = en[0];

  // Shared config-derived values; the user must keep configuration static while words are in flight (not enforced).
  logic [rrsa_pkg::DIM_W-1:0]         w_eff, h_eff;
  logic signed [rrsa_pkg::Q8_W-1:0]   shx, shy, cx, cy;
  logic signed [rrsa_pkg::TRIG_W-1:0] cos_s, sin_s;

  assign w_eff = rrsa_pkg::clamp_dim(cfg_i.image_width);
  assign h_eff = rrsa_pkg::clamp_dim(cfg_i.image_height);
  assign shx   = rrsa_pkg::Q8_W'($signed(cfg_i.shift_x));
  assign shy   = rrsa_pkg::Q8_W'($signed(cfg_i.shift_y));
  assign cos_s = $signed(cfg_i.cos_angle);
  assign sin_s = $signed(cfg_i.sin_angle);
  assign cx = $signed({{PAD_W{1'b0}}, w_eff[rrsa_pkg::DIM_W-1:1],
                       {rrsa_pkg::POS_FRAC_BITS{1'b0}}}) - shx;
  assign cy = $signed({{PAD_W{1'b0}}, h_eff[rrsa_pkg::DIM_W-1:1],
                       {rrsa_pkg::POS_FRAC_BITS{1'b0}}}) - shy;

  // Stage 1: offsets from the rotation center, in Q.8.
  logic signed [rrsa_pkg::Q8_W-1:0] dx_d, dy_d, offx_d, offy_d;
  logic signed [rrsa_pkg::Q8_W-1:0] dx_q, dy_q, offx1_q, offy1_q;

  assign dx_d = $signed({{PAD_W{1'b0}}, in_data_i.out_x,
                         {rrsa_pkg::POS_FRAC_BITS{1'b0}}}) - cx;
  assign dy_d = $signed({{PAD_W{1'b0}}, in_data_i.out_y,
                         {rrsa_pkg::POS_FRAC_BITS{1'b0}}}) - cy;
  assign offx_d = cx - shx;
  assign offy_d = cy - shy;

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      offx1_q <= offx_d;
      offy1_q <= offy_d;
    end
  end

  // Stage 2: the four rotation products.
  logic signed [rrsa_pkg::PROD_W-1:0] pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [rrsa_pkg::Q8_W-1:0]   offx2_q, offy2_q;

  always_ff @(posedge clk_i) begin
    if (en[1] && v_q[0]) begin
      pxc_q   <= dx_q * cos_s;
      pys_q   <= dy_q * sin_s;
      pxs_q   <= dx_q * sin_s;
      pyc_q   <= dy_q * cos_s;
      offx2_q <= offx1_q;
      offy2_q <= offy1_q;
    end
  end

  // Stage 3: rotated position plus the translation term, in Q.(8+T).
  logic signed [rrsa_pkg::SUM_W-1:0] sx_d, sy_d, sx_q, sy_q;

  assign sx_d = rrsa_pkg::SUM_W'(pxc_q) - rrsa_pkg::SUM_W'(pys_q)
              + (rrsa_pkg::SUM_W'(offx2_q) <<< rrsa_pkg::TRIG_FRACTION_BITS);
  assign sy_d = rrsa_pkg::SUM_W'(pxs_q) + rrsa_pkg::SUM_W'(pyc_q)
              + (rrsa_pkg::SUM_W'(offy2_q) <<< rrsa_pkg::TRIG_FRACTION_BITS);

  always_ff @(posedge clk_i) begin
    if (en[2] && v_q[1]) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
  end

  // Stage 4: truncate toward zero and check bounds. A negative value gets the
  // all-ones fraction added first so that the arithmetic shift rounds up.
  logic [rrsa_pkg::SUM_W-1:0]        bias_x, bias_y, tx, ty;
  logic [rrsa_pkg::INT_W-1:0]        ix, iy;
  logic                              src_in;
  logic [rrsa_pkg::COORD_W-1:0]      x4_q, y4_q;
  logic                              outside4_q;

  assign bias_x = sx_q[rrsa_pkg::SUM_W-1] ?
                  {{(rrsa_pkg::SUM_W-rrsa_pkg::SCALE_BITS){1'b0}},
                   {rrsa_pkg::SCALE_BITS{1'b1}}} : '0;
  assign bias_y = sy_q[rrsa_pkg::SUM_W-1] ?
                  {{(rrsa_pkg::SUM_W-rrsa_pkg::SCALE_BITS){1'b0}},
                   {rrsa_pkg::SCALE_BITS{1'b1}}} : '0;
  assign tx = sx_q + bias_x;
  assign ty = sy_q + bias_y;
  assign ix = tx[rrsa_pkg::SUM_W-1:rrsa_pkg::SCALE_BITS];
  assign iy = ty[rrsa_pkg::SUM_W-1:rrsa_pkg::SCALE_BITS];

  assign src_in = !ix[rrsa_pkg::INT_W-1] && !iy[rrsa_pkg::INT_W-1]
               && (ix[rrsa_pkg::INT_W-2:0] < (rrsa_pkg::INT_W-1)'(w_eff))
               && (iy[rrsa_pkg::INT_W-2:0] < (rrsa_pkg::INT_W-1)'(h_eff));

  always_ff @(posedge clk_i) begin
    if (en[3] && v_q[2]) begin
      x4_q       <= src_in ? ix[rrsa_pkg::COORD_W-1:0] : '0;
      y4_q       <= src_in ? iy[rrsa_pkg::COORD_W-1:0] : '0;
      outside4_q <= !src_in;
    end
  end

  // Stage 5: linear index; zeroed coordinates give a zero index when outside.
  logic [rrsa_pkg::DIM_W+rrsa_pkg::COORD_W-1:0] idx_full;
  rrsa_pkg::out_t                               out_q;

  assign idx_full = (rrsa_pkg::DIM_W + rrsa_pkg::COORD_W)'(x4_q)
                  + w_eff * y4_q;

  always_ff @(posedge clk_i) begin
    if (en[4] && v_q[3]) begin
      out_q.src_x     <= x4_q;
      out_q.src_y     <= y4_q;
      out_q.src_index <= idx_full[rrsa_pkg::INDEX_W-1:0];
      out_q.outside   <= outside4_q;
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q) && !out_ready_i)
    else $error("input stalled while the pipeline had room");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outside |->
      out_data_o.src_x == '0 && out_data_o.src_y == '0 && out_data_o.src_index == '0)
    else $error("outside word carries nonzero source fields");

  a_first_stage_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> $past(in_valid_i && in_ready_o) || $past(v_q[0]))
    else $error("first stage became valid without an accepted word");

  a_last_stage_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] |-> $past(v_q[NS-2]) || $past(v_q[NS-1]))
    else $error("output became valid without a word in the stage before");
`endif

endmodule
